// ===== hdl/fvr_pkg.sv =====
// Package for the V/f frequency ramp stabilizer: shared constants, the
// configuration and result structs, and fixed-point helper functions.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fvr_pkg;

    // Default number of fraction bits of the signed fixed-point format.
    localparam int FRAC_BITS_DEF = 28;

    // Port widths.
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 32;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;

    // Shared multiplier operand and product widths.
    localparam int OP_W   = 33;
    localparam int PROD_W = 2 * OP_W;

    // Register indexes on the configuration port.
    typedef enum logic [IDX_W-1:0] {
        REG_RAMP_STEP         = 3'd0,
        REG_BOOST_VOLTAGE     = 3'd1,
        REG_VOLTS_PER_HERTZ   = 3'd2,
        REG_HPF_INPUT_GAIN    = 3'd3,
        REG_HPF_FEEDBACK_GAIN = 3'd4,
        REG_DAMPING_GAIN      = 3'd5,
        REG_DAMPING_MIN       = 3'd6,
        REG_DAMPING_MAX       = 3'd7
    } reg_idx_t;

    // Run direction codes; the remaining code holds the ramp.
    typedef enum logic [1:0] {
        DIR_STOP = 2'b00,
        DIR_FWD  = 2'b01,
        DIR_REV  = 2'b11
    } dir_t;

    // Reset codes in Q4.28, rescaled at elaboration to the chosen format.
    localparam longint RST_RAMP_STEP         = 64'sd1611;
    localparam longint RST_BOOST_VOLTAGE     = 64'sd15498658;
    localparam longint RST_VOLTS_PER_HERTZ   = 64'sd268435456;
    localparam longint RST_HPF_INPUT_GAIN    = 64'sd268330083;
    localparam longint RST_HPF_FEEDBACK_GAIN = 64'sd266754114;
    localparam longint RST_DAMPING_GAIN      = 64'sd268435;
    localparam longint RST_DAMPING_MIN       = -64'sd13421773;
    localparam longint RST_DAMPING_MAX       = 64'sd13421773;

    // Configuration register set.
    typedef struct packed {
        logic [30:0]        ramp_step;
        logic [28:0]        boost_voltage;
        logic [30:0]        volts_per_hertz;
        logic [30:0]        hpf_input_gain;
        logic [30:0]        hpf_feedback_gain;
        logic [30:0]        damping_gain;
        logic signed [31:0] damping_min;
        logic signed [31:0] damping_max;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic signed [31:0] freq_reference;
        logic signed [29:0] volt_amplitude;
        logic               output_enable;
    } res_t;

    // Rescale a Q4.28 code to frac fraction bits, truncating toward zero.
    function automatic longint from_q28(longint v, int frac);
        int d;
        d = frac - 28;
        if (d >= 0) begin
            return v <<< d;
        end else if (v < 0) begin
            return -((-v) >>> (-d));
        end else begin
            return v >>> (-d);
        end
    endfunction

    // Saturate a wide signed value to 32-bit signed.
    function automatic logic signed [31:0] sat32(logic signed [67:0] x);
        logic signed [67:0] max_v;
        logic signed [67:0] min_v;
        max_v = 68'sd2147483647;
        min_v = -68'sd2147483648;
        if (x > max_v) begin
            return 32'sh7FFF_FFFF;
        end else if (x < min_v) begin
            return 32'sh8000_0000;
        end else begin
            return x[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fvr_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on fvr_pkg for the operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module fvr_mul
    import fvr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic signed [OP_W-1:0]   op_a,
    input  wire logic signed [OP_W-1:0]   op_b,
    output logic signed [PROD_W-1:0]      prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // Full-width signed product of the two operands.
    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    // The product is registered before any further use.
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hdl/fvr_core.sv =====
// Sequencer and datapath of the V/f ramp stabilizer: ramp, high-pass filter,
// damping clamp and voltage amplitude, all products through one multiplier.
// Depends on fvr_pkg and fvr_mul.
`timescale 1ns / 1ps
`default_nettype none

module fvr_core
    import fvr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         in_dir,
    input  wire logic signed [31:0] in_cmd,
    input  wire logic signed [31:0] in_cur,
    output logic                    res_valid,
    input  wire logic               res_take,
    output res_t                    res
);

    localparam logic signed [33:0] ONE   = 34'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [67:0] ONE_W = 68'(64'sd1 <<< FRAC_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAMP,
        S_M1,
        S_M2,
        S_HPF,
        S_M3,
        S_STAB,
        S_FREF,
        S_M4,
        S_SLOPE,
        S_M5,
        S_VOLT,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [1:0]               dir_reg;
    logic signed [31:0]       cmd_reg;
    logic signed [31:0]       cur_reg;
    logic signed [31:0]       f_reg;
    logic signed [32:0]       diff_reg;
    logic signed [31:0]       prev_cur_reg;
    logic signed [31:0]       prev_out_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [31:0]       stab_reg;
    logic signed [31:0]       fref_reg;
    logic                     pos_reg;
    logic signed [31:0]       slope_reg;
    logic signed [29:0]       volt_reg;

    logic signed [OP_W-1:0]   op_a;
    logic signed [OP_W-1:0]   op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_sh;

    logic signed [33:0]       f_w;
    logic signed [33:0]       step_w;
    logic signed [33:0]       cmd_w;
    logic signed [33:0]       ncmd_w;
    logic signed [33:0]       ramp_w;
    logic signed [31:0]       f_next;
    logic signed [32:0]       diff_next;

    logic signed [31:0]       hpf_next;
    logic signed [31:0]       stab_raw;
    logic signed [32:0]       stab_sgn;
    logic signed [32:0]       stab_lo;
    logic signed [32:0]       stab_hi;
    logic signed [31:0]       fref_next;
    logic signed [31:0]       slope_next;
    logic signed [32:0]       one_m_boost;
    logic signed [32:0]       boost_m_one;
    logic signed [67:0]       boost_w;
    logic signed [67:0]       volt_lin;
    logic signed [67:0]       volt_sel;
    logic signed [67:0]       volt_clip;
    logic                     absf_ok;

    // Shared multiplier.
    fvr_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Arithmetic shift rounds the product toward minus infinity.
    assign prod_sh = prod >>> FRAC_BITS;

    // Ramp of the kept frequency toward zero or the signed command.
    assign f_w    = 34'(f_reg);
    assign step_w = signed'({3'b000, cfg.ramp_step});
    assign cmd_w  = 34'(cmd_reg);
    assign ncmd_w = -cmd_w;

    always_comb begin
        case (dir_t'(dir_reg))
            DIR_STOP: begin
                if (f_w > step_w) begin
                    ramp_w = f_w - step_w;
                end else if (f_w < -step_w) begin
                    ramp_w = f_w + step_w;
                end else begin
                    ramp_w = '0;
                end
            end
            DIR_FWD: begin
                if (f_w <= cmd_w) begin
                    ramp_w = f_w + step_w;
                end else if (cmd_w <= f_w - step_w) begin
                    ramp_w = f_w - step_w;
                end else begin
                    ramp_w = f_w;
                end
            end
            DIR_REV: begin
                if (ncmd_w <= f_w) begin
                    ramp_w = f_w - step_w;
                end else if (f_w + step_w <= ncmd_w) begin
                    ramp_w = f_w + step_w;
                end else begin
                    ramp_w = f_w;
                end
            end
            default: begin
                ramp_w = f_w;
            end
        endcase
    end

    assign f_next    = sat32(68'(ramp_w));
    assign diff_next = 33'(cur_reg) - 33'(prev_cur_reg);

    // Filter output: sum of the two stored products.
    assign hpf_next = sat32(68'(prod_sh) + 68'(acc_reg));

    // Damping term: sign of the frequency, then lower and upper clamp.
    assign stab_raw = sat32(68'(prod_sh));
    assign stab_sgn = (f_reg < 0) ? -33'(stab_raw) : 33'(stab_raw);
    assign stab_lo  = (stab_sgn < 33'(cfg.damping_min)) ? 33'(cfg.damping_min) : stab_sgn;
    assign stab_hi  = (stab_lo > 33'(cfg.damping_max)) ? 33'(cfg.damping_max) : stab_lo;

    assign fref_next = sat32(68'(f_reg) - 68'(stab_reg));

    // Voltage slope and amplitude.
    assign one_m_boost = 33'(ONE) - signed'({4'b0000, cfg.boost_voltage});
    assign boost_m_one = signed'({4'b0000, cfg.boost_voltage}) - 33'(ONE);
    assign slope_next  = sat32(68'(prod_sh));
    assign boost_w     = 68'(signed'({1'b0, cfg.boost_voltage}));
    assign absf_ok     = (f_w <= ONE) && (f_w >= -ONE);
    assign volt_lin    = pos_reg ? (68'(prod_sh) + boost_w) : (68'(prod_sh) - boost_w);

    always_comb begin
        if (absf_ok) begin
            volt_sel = volt_lin;
        end else begin
            volt_sel = pos_reg ? ONE_W : -ONE_W;
        end
        if (volt_sel < -ONE_W) begin
            volt_clip = -ONE_W;
        end else if (volt_sel > ONE_W) begin
            volt_clip = ONE_W;
        end else begin
            volt_clip = volt_sel;
        end
    end

    // Multiplier operand selection per step.
    always_comb begin
        case (state_reg)
            S_M1: begin
                op_a = signed'({2'b00, cfg.hpf_input_gain});
                op_b = diff_reg;
            end
            S_M2: begin
                op_a = signed'({2'b00, cfg.hpf_feedback_gain});
                op_b = 33'(prev_out_reg);
            end
            S_M3: begin
                op_a = signed'({2'b00, cfg.damping_gain});
                op_b = 33'(prev_out_reg);
            end
            S_M4: begin
                op_a = signed'({2'b00, cfg.volts_per_hertz});
                op_b = pos_reg ? one_m_boost : boost_m_one;
            end
            S_M5: begin
                op_a = 33'(slope_reg);
                op_b = pos_reg ? 33'(fref_reg) : -33'(fref_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Sequencer with its state and stored values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            f_reg        <= '0;
            prev_cur_reg <= '0;
            prev_out_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        dir_reg   <= in_dir;
                        cmd_reg   <= in_cmd;
                        cur_reg   <= in_cur;
                        state_reg <= S_RAMP;
                    end
                end
                S_RAMP: begin
                    f_reg     <= f_next;
                    diff_reg  <= diff_next;
                    state_reg <= S_M1;
                end
                S_M1: begin
                    state_reg <= S_M2;
                end
                S_M2: begin
                    acc_reg   <= prod_sh;
                    state_reg <= S_HPF;
                end
                S_HPF: begin
                    prev_out_reg <= hpf_next;
                    prev_cur_reg <= cur_reg;
                    state_reg    <= S_M3;
                end
                S_M3: begin
                    state_reg <= S_STAB;
                end
                S_STAB: begin
                    stab_reg  <= stab_hi[31:0];
                    state_reg <= S_FREF;
                end
                S_FREF: begin
                    fref_reg  <= fref_next;
                    pos_reg   <= (fref_next > 0);
                    state_reg <= S_M4;
                end
                S_M4: begin
                    state_reg <= S_SLOPE;
                end
                S_SLOPE: begin
                    slope_reg <= slope_next;
                    state_reg <= S_M5;
                end
                S_M5: begin
                    state_reg <= S_VOLT;
                end
                S_VOLT: begin
                    volt_reg  <= volt_clip[29:0];
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (res_take) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready                 = (state_reg == S_IDLE);
    assign res_valid                = (state_reg == S_DONE);
    assign res.freq_reference       = fref_reg;
    assign res.volt_amplitude       = volt_reg;
    assign res.output_enable        = (f_reg != 0);

endmodule

`default_nettype wire

// ===== hdl/vf_frequency_ramp_stabilizer.sv =====
// V/f frequency ramp stabilizer, top level: configuration registers, the
// input and output stream ports and the output register.
// Depends on fvr_pkg and fvr_core.
//
// Usage:
// One input beat per control tick on s_* carries direction, freq_command
// and active_current. The block ramps its kept frequency, filters and damps
// the current, and returns one result beat on m_* with freq_reference,
// volt_amplitude and output_enable.
// m_tvalid rises once the sequencer has run its steps on an accepted beat
// and the result is loaded into the output register. s_tready is low while
// an item is being worked, so only one item is in work at a time. Every
// product goes through one shared multiplier in a sequencer of eleven steps.
// The result sits in an output register, so the next item may enter while
// the receiver stalls; a further result waits in the core until the output
// register is free, and s_tready stays low meanwhile.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready; write only
// while the block is idle.
// Reset (aresetn low, synchronous): the ramp frequency and filter state go
// to zero, the registers to their defaults, and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module vf_frequency_ramp_stabilizer
    import fvr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata from bit 0: direction[1:0], freq_command[33:2],
    // active_current[65:34], zero fill.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata from bit 0: freq_reference[31:0], volt_amplitude[61:32],
    // output_enable[62], zero fill.
    output logic [M_TDATA_W-1:0]       m_tdata
);

    cfg_t                 cfg_reg;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    res_t                 res_reg;
    logic                 core_valid;
    logic                 core_take;
    res_t                 core_res;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ramp_step         <= 31'(from_q28(RST_RAMP_STEP, FRAC_BITS));
            cfg_reg.boost_voltage     <= 29'(from_q28(RST_BOOST_VOLTAGE, FRAC_BITS));
            cfg_reg.volts_per_hertz   <= 31'(from_q28(RST_VOLTS_PER_HERTZ, FRAC_BITS));
            cfg_reg.hpf_input_gain    <= 31'(from_q28(RST_HPF_INPUT_GAIN, FRAC_BITS));
            cfg_reg.hpf_feedback_gain <= 31'(from_q28(RST_HPF_FEEDBACK_GAIN, FRAC_BITS));
            cfg_reg.damping_gain      <= 31'(from_q28(RST_DAMPING_GAIN, FRAC_BITS));
            cfg_reg.damping_min       <= 32'(from_q28(RST_DAMPING_MIN, FRAC_BITS));
            cfg_reg.damping_max       <= 32'(from_q28(RST_DAMPING_MAX, FRAC_BITS));
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_RAMP_STEP:         cfg_reg.ramp_step         <= cfg_data[30:0];
                REG_BOOST_VOLTAGE:     cfg_reg.boost_voltage     <= cfg_data[28:0];
                REG_VOLTS_PER_HERTZ:   cfg_reg.volts_per_hertz   <= cfg_data[30:0];
                REG_HPF_INPUT_GAIN:    cfg_reg.hpf_input_gain    <= cfg_data[30:0];
                REG_HPF_FEEDBACK_GAIN: cfg_reg.hpf_feedback_gain <= cfg_data[30:0];
                REG_DAMPING_GAIN:      cfg_reg.damping_gain      <= cfg_data[30:0];
                REG_DAMPING_MIN:       cfg_reg.damping_min       <= cfg_data;
                REG_DAMPING_MAX:       cfg_reg.damping_max       <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Sequenced datapath.
    fvr_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_dir    (s_tdata[1:0]),
        .in_cmd    (s_tdata[33:2]),
        .in_cur    (s_tdata[65:34]),
        .res_valid (core_valid),
        .res_take  (core_take),
        .res       (core_res)
    );

    // Output register: loads when empty or when its beat is taken.
    assign core_take     = core_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid_next = core_take || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_take) begin
            res_reg <= core_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg.output_enable, res_reg.volt_amplitude,
                       res_reg.freq_reference};

endmodule

`default_nettype wire

// ===== hdl/fvr_checker.sv =====
// Port-level checker for the V/f ramp stabilizer, bound to the top level.
// Depends on fvr_pkg and on the ports of vf_frequency_ramp_stabilizer.
`timescale 1ns / 1ps
`default_nettype none

module fvr_checker
    import fvr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic signed [31:0] ONE_Q = 32'(64'sd1 <<< FRAC_BITS);

    logic signed [31:0] volt_w;

    assign volt_w = 32'(signed'(m_tdata[61:32]));

    // A stalled result beat holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // One item at a time: ready drops after every accepted input beat.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // When FRAC_BITS is at most 28, the voltage amplitude stays within plus and minus one.
    a_volt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (FRAC_BITS > 28) || ((volt_w <= ONE_Q) && (volt_w >= -ONE_Q)))
        else $error("voltage amplitude out of range");

endmodule

bind vf_frequency_ramp_stabilizer fvr_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_fvr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== test/fvr_drive_checker.sv =====
// Checker for the V/f frequency ramp stabilizer: watches the configuration,
// input and result channels, predicts every result beat and compares it.
// Depends on fvr_pkg for the register indexes, direction codes and result struct.
`timescale 1ns / 1ps

module fvr_drive_checker
    import fvr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    // s_tdata from bit 0: direction, freq_command, active_current, zero fill.
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata from bit 0: freq_reference, volt_amplitude, output_enable, zero fill.
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        drive_outstanding
);

    // Shadow copy of the configuration registers.
    longint step_size, boost, vf_ratio, hp_in_gain, hp_fb_gain;
    longint damp_gain, damp_lo, damp_hi;

    // Shadow copy of the tick state.
    longint freq_now, last_current, last_hp_out;

    // Results predicted but not yet seen on the result channel.
    res_t predicted_drive[$];
    int   mismatches = 0;

    initial begin
        fail_count        = 0;
        drive_outstanding = 0;
    end

    // Convert a Q4.28 reset code to the configured number of fraction bits.
    function automatic longint rescale_q28(longint v);
        int d;
        d = FRAC_BITS - 28;
        if (d >= 0) begin
            return v <<< d;
        end
        return v / (longint'(1) <<< (-d));
    endfunction

    // Clip to the 32-bit signed range.
    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // Fixed-point product, rounded toward minus infinity.
    function automatic longint mul_q(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    // One control tick: ramp, high-pass damping and V/f amplitude.
    function automatic res_t ramp_and_damp(logic [1:0] dir_code,
                                           logic signed [31:0] cmd_in,
                                           logic signed [31:0] cur_in);
        longint one, f, cmd, cur, hp, damp, fref, mag, slope, volt;
        res_t   r;
        one = longint'(1) <<< FRAC_BITS;
        f   = freq_now;
        cmd = longint'(cmd_in);
        cur = longint'(cur_in);

        // Ramp toward zero or toward the signed command.
        case (dir_t'(dir_code))
            DIR_STOP: begin
                if (f > step_size) f = f - step_size;
                else if (f < -step_size) f = f + step_size;
                else f = 0;
            end
            DIR_FWD: begin
                if (f <= cmd) f = f + step_size;
                else if (cmd <= f - step_size) f = f - step_size;
            end
            DIR_REV: begin
                if (-cmd <= f) f = f - step_size;
                else if (f + step_size <= -cmd) f = f + step_size;
            end
            default: begin
                // The spare code leaves the ramp where it is.
            end
        endcase
        f = clip32(f);
        freq_now = f;

        // High-pass the current, then scale, sign and clamp the damping term.
        hp   = clip32(mul_q(hp_in_gain, cur - last_current) +
                      mul_q(hp_fb_gain, last_hp_out));
        damp = clip32(mul_q(damp_gain, hp));
        last_current = cur;
        last_hp_out  = hp;
        if (f < 0) damp = -damp;
        if (damp < damp_lo) damp = damp_lo;
        if (damp > damp_hi) damp = damp_hi;
        fref = clip32(f - damp);

        // Voltage amplitude with boost, limited to plus or minus one.
        mag = (f < 0) ? -f : f;
        if (mag <= one) begin
            if (fref > 0) begin
                slope = clip32(mul_q(vf_ratio, one - boost));
                volt  = mul_q(slope, fref) + boost;
            end else begin
                slope = clip32(mul_q(vf_ratio, boost - one));
                volt  = mul_q(slope, -fref) - boost;
            end
        end else begin
            volt = (fref > 0) ? one : -one;
        end
        if (volt < -one) volt = -one;
        if (volt > one) volt = one;

        r.freq_reference = fref[31:0];
        r.volt_amplitude = volt[29:0];
        r.output_enable  = (f != 0);
        return r;
    endfunction

    // Track register writes, predict on each input beat, compare each result beat.
    always @(posedge aclk) begin
        res_t want;
        res_t seen;
        if (!aresetn) begin
            step_size    = rescale_q28(RST_RAMP_STEP);
            boost        = rescale_q28(RST_BOOST_VOLTAGE);
            vf_ratio     = rescale_q28(RST_VOLTS_PER_HERTZ);
            hp_in_gain   = rescale_q28(RST_HPF_INPUT_GAIN);
            hp_fb_gain   = rescale_q28(RST_HPF_FEEDBACK_GAIN);
            damp_gain    = rescale_q28(RST_DAMPING_GAIN);
            damp_lo      = rescale_q28(RST_DAMPING_MIN);
            damp_hi      = rescale_q28(RST_DAMPING_MAX);
            freq_now     = 0;
            last_current = 0;
            last_hp_out  = 0;
            predicted_drive.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_index))
                    REG_RAMP_STEP:         step_size  = longint'({33'd0, cfg_data[30:0]});
                    REG_BOOST_VOLTAGE:     boost      = longint'({35'd0, cfg_data[28:0]});
                    REG_VOLTS_PER_HERTZ:   vf_ratio   = longint'({33'd0, cfg_data[30:0]});
                    REG_HPF_INPUT_GAIN:    hp_in_gain = longint'({33'd0, cfg_data[30:0]});
                    REG_HPF_FEEDBACK_GAIN: hp_fb_gain = longint'({33'd0, cfg_data[30:0]});
                    REG_DAMPING_GAIN:      damp_gain  = longint'({33'd0, cfg_data[30:0]});
                    REG_DAMPING_MIN:       damp_lo    = longint'($signed(cfg_data));
                    REG_DAMPING_MAX:       damp_hi    = longint'($signed(cfg_data));
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                predicted_drive.push_back(ramp_and_damp(s_tdata[1:0], s_tdata[33:2],
                                                        s_tdata[65:34]));
            end

            if (m_tvalid && m_tready) begin
                seen.freq_reference = m_tdata[31:0];
                seen.volt_amplitude = m_tdata[61:32];
                seen.output_enable  = m_tdata[62];
                if (predicted_drive.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result beat with nothing expected: fref=%0d volt=%0d en=%0b",
                                 $realtime, seen.freq_reference, seen.volt_amplitude,
                                 seen.output_enable);
                    end
                    mismatches++;
                end else begin
                    want = predicted_drive.pop_front();
                    if (seen.freq_reference !== want.freq_reference ||
                        seen.volt_amplitude !== want.volt_amplitude ||
                        seen.output_enable  !== want.output_enable) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch fref exp %0d got %0d, volt exp %0d got %0d, en exp %0b got %0b",
                                     $realtime, want.freq_reference, seen.freq_reference,
                                     want.volt_amplitude, seen.volt_amplitude,
                                     want.output_enable, seen.output_enable);
                        end
                        mismatches++;
                    end
                end
            end
        end
        drive_outstanding <= predicted_drive.size();
        fail_count        <= mismatches;
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the V/f frequency ramp stabilizer: clock, reset, register
// setup, directed and random ticks, flow-control patterns and the verdict.
// Depends on fvr_pkg, vf_frequency_ramp_stabilizer and fvr_drive_checker.
`timescale 1ns / 1ps

module tb_top;
    import fvr_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_TICKS  = 140;
    localparam int HOLD_CYCLES  = 400;
    // The direction code that no operation uses.
    localparam logic [1:0] DIR_SPARE = 2'b10;

    // Register sets used across the run.
    typedef enum int {
        SET_DEFAULT,
        SET_CEILING,
        SET_FLOOR,
        SET_TYPICAL,
        SET_WILD,
        SET_FAST
    } reg_set_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int   fail_count;
    int   drive_outstanding;
    int   idle_pct    = 0;
    int   stall_pct   = 0;
    logic hold_go     = 1'b0;
    int   hold_left   = 0;
    int   cycle_count = 0;

    vf_frequency_ramp_stabilizer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    fvr_drive_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .fail_count        (fail_count),
        .drive_outstanding (drive_outstanding)
    );

    // 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Long receiver hold-off, counted down here once started.
    always @(posedge aclk) begin
        if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: random stalls plus the long hold-off.
    always @(posedge aclk) begin
        m_tready <= !hold_go && hold_left == 0 && ($urandom_range(99) >= stall_pct);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one tick on the input channel, with random idle cycles before it.
    task automatic offer_tick(input logic [1:0] dir_code, input logic [31:0] cmd,
                              input logic [31:0] cur);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, cur, cmd, dir_code};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (drive_outstanding != 0 || hold_left != 0) @(posedge aclk);
    endtask

    // Write all eight registers with one of the prepared sets.
    task automatic load_setting(input reg_set_t kind);
        logic [31:0] val [8];
        int          i;
        case (kind)
            SET_DEFAULT: begin
                val[REG_RAMP_STEP]         = 32'(RST_RAMP_STEP);
                val[REG_BOOST_VOLTAGE]     = 32'(RST_BOOST_VOLTAGE);
                val[REG_VOLTS_PER_HERTZ]   = 32'(RST_VOLTS_PER_HERTZ);
                val[REG_HPF_INPUT_GAIN]    = 32'(RST_HPF_INPUT_GAIN);
                val[REG_HPF_FEEDBACK_GAIN] = 32'(RST_HPF_FEEDBACK_GAIN);
                val[REG_DAMPING_GAIN]      = 32'(RST_DAMPING_GAIN);
                val[REG_DAMPING_MIN]       = 32'(RST_DAMPING_MIN);
                val[REG_DAMPING_MAX]       = 32'(RST_DAMPING_MAX);
            end
            SET_CEILING: begin
                val[REG_RAMP_STEP]         = 32'h7FFF_FFFF;
                val[REG_BOOST_VOLTAGE]     = 32'h1000_0000;
                val[REG_VOLTS_PER_HERTZ]   = 32'h7FFF_FFFF;
                val[REG_HPF_INPUT_GAIN]    = 32'h7FFF_FFFF;
                val[REG_HPF_FEEDBACK_GAIN] = 32'h7FFF_FFFF;
                val[REG_DAMPING_GAIN]      = 32'h7FFF_FFFF;
                val[REG_DAMPING_MIN]       = 32'h8000_0000;
                val[REG_DAMPING_MAX]       = 32'h7FFF_FFFF;
            end
            SET_FLOOR: begin
                for (i = 0; i < 8; i++) val[i] = '0;
            end
            SET_TYPICAL: begin
                val[REG_RAMP_STEP]         = $urandom_range(32'h0400_0000, 32'h0010_0000);
                val[REG_BOOST_VOLTAGE]     = $urandom_range(32'h1000_0000, 0);
                val[REG_VOLTS_PER_HERTZ]   = $urandom_range(32'h2000_0000, 32'h0800_0000);
                val[REG_HPF_INPUT_GAIN]    = $urandom_range(32'h1000_0000, 32'h0FF0_0000);
                val[REG_HPF_FEEDBACK_GAIN] = $urandom_range(32'h1000_0000, 32'h0F00_0000);
                val[REG_DAMPING_GAIN]      = $urandom_range(32'h0400_0000, 0);
                val[REG_DAMPING_MIN]       = -$urandom_range(32'h0400_0000, 0);
                val[REG_DAMPING_MAX]       = $urandom_range(32'h0400_0000, 0);
            end
            SET_WILD: begin
                val[REG_RAMP_STEP]         = $urandom_range(32'h7FFF_FFFF, 0);
                val[REG_BOOST_VOLTAGE]     = $urandom_range(32'h1000_0000, 0);
                val[REG_VOLTS_PER_HERTZ]   = $urandom_range(32'h7FFF_FFFF, 0);
                val[REG_HPF_INPUT_GAIN]    = $urandom_range(32'h7FFF_FFFF, 0);
                val[REG_HPF_FEEDBACK_GAIN] = $urandom_range(32'h7FFF_FFFF, 0);
                val[REG_DAMPING_GAIN]      = $urandom_range(32'h7FFF_FFFF, 0);
                val[REG_DAMPING_MIN]       = $urandom;
                val[REG_DAMPING_MAX]       = $urandom;
            end
            default: begin
                // Big steps, strong damping and an inverted clamp.
                val[REG_RAMP_STEP]         = 32'h4000_0000;
                val[REG_BOOST_VOLTAGE]     = 32'(RST_BOOST_VOLTAGE);
                val[REG_VOLTS_PER_HERTZ]   = 32'h1000_0000;
                val[REG_HPF_INPUT_GAIN]    = 32'(RST_HPF_INPUT_GAIN);
                val[REG_HPF_FEEDBACK_GAIN] = 32'(RST_HPF_FEEDBACK_GAIN);
                val[REG_DAMPING_GAIN]      = 32'h7FFF_FFFF;
                val[REG_DAMPING_MIN]       = 32'h0100_0000;
                val[REG_DAMPING_MAX]       = 32'hFF00_0000;
            end
        endcase
        for (i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= i[IDX_W-1:0];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Main sequence: reset, directed ticks, then random phases.
    initial begin
        reg_set_t    plan [8];
        int          phase;
        int          sent;
        int          run_len;
        int          r;
        logic [1:0]  run_dir;
        logic [31:0] run_cmd;
        logic [31:0] cur;
        int          cur_walk;

        plan = '{SET_TYPICAL, SET_CEILING, SET_TYPICAL, SET_FLOOR,
                 SET_WILD, SET_TYPICAL, SET_DEFAULT, SET_WILD};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks at the reset settings: extremes of every field.
        offer_tick(DIR_STOP, 32'h0000_0000, 32'h0000_0000);
        offer_tick(DIR_FWD,  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        offer_tick(DIR_FWD,  32'h7FFF_FFFF, 32'h8000_0000);
        offer_tick(DIR_REV,  32'h8000_0000, 32'h0000_0000);
        offer_tick(DIR_SPARE, 32'hFFFF_FFFF, 32'h1234_5678);
        offer_tick(DIR_STOP, 32'h0000_0000, 32'hFFFF_FFFF);
        wait_drained();

        // Directed ticks with big steps: magnitude above one, ramp saturation,
        // stopping to zero, reverse with the most negative command, the spare
        // direction, dithering around the target and the inverted clamp.
        load_setting(SET_FAST);
        offer_tick(DIR_FWD,  32'h2000_0000, 32'h7FFF_FFFF);
        offer_tick(DIR_FWD,  32'h2000_0000, 32'h8000_0000);
        offer_tick(DIR_FWD,  32'h7FFF_FFFF, 32'h0000_0000);
        offer_tick(DIR_FWD,  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        offer_tick(DIR_STOP, 32'h0000_0000, 32'h0000_0000);
        offer_tick(DIR_STOP, 32'h0000_0000, 32'h8000_0000);
        offer_tick(DIR_REV,  32'h7FFF_FFFF, 32'h8000_0000);
        offer_tick(DIR_REV,  32'h8000_0000, 32'h7FFF_FFFF);
        offer_tick(DIR_REV,  32'h7FFF_FFFF, 32'h0000_0000);
        offer_tick(DIR_REV,  32'h7FFF_FFFF, 32'h0100_0000);
        offer_tick(DIR_REV,  32'h7FFF_FFFF, 32'hFF00_0000);
        offer_tick(DIR_SPARE, 32'h5555_5555, 32'hAAAA_AAAA);
        offer_tick(DIR_FWD,  32'h0000_0000, 32'h0000_0000);
        offer_tick(DIR_FWD,  32'h0000_0000, 32'h0000_0000);
        offer_tick(DIR_FWD,  32'h0000_0000, 32'h0000_0000);
        offer_tick(DIR_FWD,  32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // Random phases: runs of one direction and command with a wandering
        // current, mixed with fully random noise ticks.
        for (phase = 0; phase < 8; phase++) begin
            load_setting(plan[phase]);
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 63; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            if (phase % 4 == 0) begin
                hold_go <= 1'b1;
                @(posedge aclk);
                hold_go <= 1'b0;
            end
            sent     = 0;
            cur_walk = 0;
            while (sent < PHASE_TICKS) begin
                r = $urandom_range(99);
                if (r < 40) run_dir = DIR_FWD;
                else if (r < 75) run_dir = DIR_REV;
                else if (r < 95) run_dir = DIR_STOP;
                else run_dir = DIR_SPARE;
                if ($urandom_range(99) < 70) begin
                    run_cmd = $urandom_range(32'h2000_0000, 0);
                    if ($urandom_range(1) == 1) run_cmd = -run_cmd;
                end else begin
                    run_cmd = $urandom;
                end
                run_len = $urandom_range(40, 5);
                while (run_len > 0 && sent < PHASE_TICKS) begin
                    cur_walk = cur_walk + int'($urandom_range(32'h0010_0000, 0))
                               - int'(32'h0008_0000);
                    if (cur_walk > int'(32'h1000_0000) || cur_walk < -int'(32'h1000_0000))
                        cur_walk = 0;
                    cur = ($urandom_range(99) < 10) ? $urandom : cur_walk;
                    if ($urandom_range(99) < 8) begin
                        offer_tick(2'($urandom), $urandom, $urandom);
                    end else begin
                        offer_tick(run_dir, run_cmd, cur);
                    end
                    sent++;
                    run_len--;
                end
            end
            wait_drained();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
